FILE: sv/dttw_pkg.sv
// Shared types and constants for the device tree token walker.
package dttw_pkg;

  localparam int OFFSET_BITS_DEF = 22;
  localparam int MAX_DEPTH_DEF   = 64;

  localparam int WORD_W       = 32;
  localparam int KIND_W       = 3;
  localparam int TAG_OFFSET_W = 22;
  localparam int DEPTH_W      = 7;
  localparam int LEFT_W       = 30;
  localparam int OUT_DATA_W   = 96;

  localparam logic [1:0] ROUND_UP = 2'd3;

  localparam logic [WORD_W-1:0] TAG_BEGIN_NODE = 32'h0000_0001;
  localparam logic [WORD_W-1:0] TAG_END_NODE   = 32'h0000_0002;
  localparam logic [WORD_W-1:0] TAG_PROP       = 32'h0000_0003;
  localparam logic [WORD_W-1:0] TAG_NOP        = 32'h0000_0004;
  localparam logic [WORD_W-1:0] TAG_END        = 32'h0000_0009;

  typedef enum logic [4:0] {
    MODE_TAG   = 5'b00001,
    MODE_NAME  = 5'b00010,
    MODE_PLEN  = 5'b00100,
    MODE_PNAME = 5'b01000,
    MODE_DATA  = 5'b10000
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    EV_BEGIN    = 3'd0,
    EV_PROP     = 3'd1,
    EV_END_NODE = 3'd2,
    EV_END      = 3'd3,
    EV_ERROR    = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic                    valid;
    ev_kind_t                kind;
    logic [TAG_OFFSET_W-1:0] tag_offset;
    logic [DEPTH_W-1:0]      depth;
    logic [WORD_W-1:0]       str_offset;
    logic [WORD_W-1:0]       prop_length;
  } event_t;

endpackage

FILE: sv/dttw_in_reg.sv
// Input register stage for structure-block words.
module dttw_in_reg
  import dttw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [WORD_W-1:0] in_word,
  input  logic              in_first,
  input  logic              advance,
  output logic              hold_valid,
  output logic [WORD_W-1:0] hold_word,
  output logic              hold_first
);

  logic              valid_r;
  logic              valid_nxt;
  logic [WORD_W-1:0] word_r;
  logic              first_r;

  assign in_tready = !valid_r || advance;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      first_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (in_tvalid && in_tready) begin
        first_r <= in_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      word_r <= in_word;
    end
  end

  assign hold_valid = valid_r;
  assign hold_word  = word_r;
  assign hold_first = first_r;

endmodule

FILE: sv/dttw_core.sv
// Parse state and per-word token decode.
module dttw_core
  import dttw_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [WORD_W-1:0] word,
  input  logic              first,
  output event_t            ev
);

  localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);

  mode_t                  mode_r, mode_nxt, mode_c;
  logic [LEFT_W-1:0]      left_r, left_nxt, left_c;
  logic [DEPTH_BITS-1:0]  depth_r, depth_nxt, depth_c;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, off_c;
  logic [WORD_W-1:0]      len_r, len_nxt, len_c;
  logic [OFFSET_BITS-1:0] start_r, start_nxt, start_c;
  logic                   fin_r, fin_nxt, fin_c;

  logic [LEFT_W:0]                      words;
  logic                                 zero_byte;
  logic [OFFSET_BITS+TAG_OFFSET_W-1:0]  here_ext;
  logic [OFFSET_BITS+TAG_OFFSET_W-1:0]  start_ext;
  logic [DEPTH_BITS+DEPTH_W-1:0]        depth_ext;
  logic [DEPTH_BITS+DEPTH_W-1:0]        depth_dec_ext;

  assign zero_byte = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                     (word[15:8] == 8'd0) || (word[7:0] == 8'd0);

  always_comb begin
    mode_c  = first ? MODE_TAG : mode_r;
    left_c  = first ? '0 : left_r;
    depth_c = first ? '0 : depth_r;
    off_c   = first ? '0 : off_r;
    len_c   = first ? '0 : len_r;
    start_c = first ? '0 : start_r;
    fin_c   = first ? 1'b0 : fin_r;

    mode_nxt  = mode_c;
    left_nxt  = left_c;
    depth_nxt = depth_c;
    off_nxt   = off_c;
    len_nxt   = len_c;
    start_nxt = start_c;
    fin_nxt   = fin_c;

    words         = (LEFT_W+1)'(({1'b0, len_c} + {{WORD_W-1{1'b0}}, ROUND_UP}) >> 2);
    here_ext      = {{TAG_OFFSET_W{1'b0}}, off_c};
    start_ext     = {{TAG_OFFSET_W{1'b0}}, start_c};
    depth_ext     = {{DEPTH_W{1'b0}}, depth_c};
    depth_dec_ext = {{DEPTH_W{1'b0}}, depth_c - 1'b1};

    ev             = '0;
    ev.kind        = EV_BEGIN;
    ev.tag_offset  = here_ext[TAG_OFFSET_W-1:0];
    ev.depth       = depth_ext[DEPTH_W-1:0];

    if (!fin_c) begin
      case (mode_c)
        MODE_NAME: begin
          if (zero_byte) begin
            mode_nxt = MODE_TAG;
          end
        end
        MODE_PLEN: begin
          len_nxt  = word;
          mode_nxt = MODE_PNAME;
        end
        MODE_PNAME: begin
          ev.valid       = 1'b1;
          ev.kind        = EV_PROP;
          ev.tag_offset  = start_ext[TAG_OFFSET_W-1:0];
          ev.str_offset  = word;
          ev.prop_length = len_c;
          if (len_c == '0) begin
            mode_nxt = MODE_TAG;
          end else begin
            left_nxt = LEFT_W'(words - 1'b1);
            mode_nxt = MODE_DATA;
          end
        end
        MODE_DATA: begin
          if (left_c == '0) begin
            mode_nxt = MODE_TAG;
          end else begin
            left_nxt = left_c - 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_TAG;
          case (word)
            TAG_BEGIN_NODE: begin
              ev.valid = 1'b1;
              if (depth_c >= DEPTH_BITS'(MAX_DEPTH)) begin
                ev.kind = EV_ERROR;
                fin_nxt = 1'b1;
              end else begin
                ev.kind   = EV_BEGIN;
                depth_nxt = depth_c + 1'b1;
                mode_nxt  = MODE_NAME;
              end
            end
            TAG_PROP: begin
              start_nxt = off_c;
              mode_nxt  = MODE_PLEN;
            end
            TAG_END_NODE: begin
              ev.valid = 1'b1;
              if (depth_c == '0) begin
                ev.kind = EV_ERROR;
                fin_nxt = 1'b1;
              end else begin
                ev.kind   = EV_END_NODE;
                depth_nxt = depth_c - 1'b1;
                ev.depth  = depth_dec_ext[DEPTH_W-1:0];
              end
            end
            TAG_NOP: begin
            end
            TAG_END: begin
              ev.valid = 1'b1;
              ev.kind  = EV_END;
              fin_nxt  = 1'b1;
            end
            default: begin
              ev.valid = 1'b1;
              ev.kind  = EV_ERROR;
              fin_nxt  = 1'b1;
            end
          endcase
        end
      endcase
      if (!fin_nxt) begin
        off_nxt = off_c + OFFSET_BITS'(4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TAG;
      left_r  <= '0;
      depth_r <= '0;
      off_r   <= '0;
      len_r   <= '0;
      start_r <= '0;
      fin_r   <= 1'b0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      left_r  <= left_nxt;
      depth_r <= depth_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

FILE: sv/dttw_out_reg.sv
// Result register that holds one event beat until it is taken.
module dttw_out_reg
  import dttw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  event_t                ev,
  output logic                  busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]     out_tuser
);

  logic   valid_r;
  logic   valid_nxt;
  event_t ev_r;

  assign busy      = valid_r && !out_tready;
  assign valid_nxt = (valid_r && !out_tready) || (load && ev.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ev.valid) begin
      ev_r <= ev;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = ev_r.kind;
  assign out_tdata  = {3'b000, ev_r.prop_length, ev_r.str_offset, ev_r.depth,
                       ev_r.tag_offset};

endmodule

FILE: sv/device_tree_token_walker.sv
// Top level of the flattened device tree structure-block token walker.
// Takes one structure-block word per clock while the result register is not
// stalled, and presents at most one event per word from the result register;
// the rate is set by the single state update that the walker core makes per word.
// A word with in_tuser set restarts the walk at offset 0 and depth 0. After an
// end token or an error, words are dropped until the next restart.
module device_tree_token_walker
  import dttw_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [WORD_W-1:0]     in_tdata,   // [31:0] word
  input  logic [0:0]            in_tuser,   // [0] first
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [21:0] tag_offset, [28:22] depth,
                                            // [60:29] str_offset, [92:61] prop_length
  output logic [KIND_W-1:0]     out_tuser   // [2:0] event_kind
);

  logic              hold_valid;
  logic [WORD_W-1:0] hold_word;
  logic              hold_first;
  logic              out_busy;
  logic              advance;
  event_t            ev;

  assign advance = hold_valid && !out_busy;

  dttw_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_word    (in_tdata),
    .in_first   (in_tuser[0]),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_word  (hold_word),
    .hold_first (hold_first)
  );

  dttw_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .word    (hold_word),
    .first   (hold_first),
    .ev      (ev)
  );

  dttw_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .ev         (ev),
    .busy       (out_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: sv/dttw_checker.sv
// Port-level checks for the token walker, bound to the top level.
module dttw_checker
  import dttw_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [KIND_W-1:0]     out_tuser
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= EV_ERROR))
    else $error("event kind out of range");

  a_prop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != EV_PROP) |-> (out_tdata[92:29] == '0))
    else $error("name or length set on a non-property event");

endmodule

bind device_tree_token_walker dttw_checker u_dttw_checker (.*);

FILE: dv/tb_device_tree_token_walker.sv
// Testbench for the device tree token walker: token streams, stop cases and depth limit.
module tb_device_tree_token_walker;
  import dttw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ev_kind_t                kind;
    logic [TAG_OFFSET_W-1:0] tag_offset;
    logic [DEPTH_W-1:0]      depth;
    logic [WORD_W-1:0]       str_offset;
    logic [WORD_W-1:0]       prop_length;
  } walk_event_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;

  device_tree_token_walker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  walk_event_t             pending_events[$];
  int                      mismatches;
  bit                      in_idle_en;
  bit                      out_idle_en;
  bit                      restart_pending;
  int                      words_sent;

  mode_t                   walk_mode;
  logic [LEFT_W-1:0]       words_to_skip;
  logic [DEPTH_W-1:0]      cur_depth;
  logic [TAG_OFFSET_W-1:0] cur_offset;
  logic [WORD_W-1:0]       pending_len;
  logic [TAG_OFFSET_W-1:0] prop_tag_offset;
  bit                      walk_stopped;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("** device_tree_token_walker: FAILED **");
    $finish;
  end

  function automatic void clear_walk();
    walk_mode       = MODE_TAG;
    words_to_skip   = '0;
    cur_depth       = '0;
    cur_offset      = '0;
    pending_len     = '0;
    prop_tag_offset = '0;
    walk_stopped    = 1'b0;
  endfunction

  function automatic bit holds_nul_byte(input logic [WORD_W-1:0] w);
    return w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 || w[7:0] == 8'h00;
  endfunction

  function automatic void walk_word(input logic [WORD_W-1:0] w, input logic first);
    walk_event_t             ev;
    logic [32:0]             word_count;
    logic [TAG_OFFSET_W-1:0] here;
    bit                      fire;
    ev   = '0;
    fire = 1'b0;
    if (first) clear_walk();
    if (walk_stopped) return;
    here = cur_offset;
    case (walk_mode)
      MODE_NAME: begin
        if (holds_nul_byte(w)) walk_mode = MODE_TAG;
      end
      MODE_PLEN: begin
        pending_len = w;
        walk_mode   = MODE_PNAME;
      end
      MODE_PNAME: begin
        word_count     = ({1'b0, pending_len} + 33'd3) >> 2;
        ev.kind        = EV_PROP;
        ev.tag_offset  = prop_tag_offset;
        ev.depth       = cur_depth;
        ev.str_offset  = w;
        ev.prop_length = pending_len;
        fire           = 1'b1;
        if (word_count == 33'd0) begin
          walk_mode = MODE_TAG;
        end else begin
          words_to_skip = LEFT_W'(word_count - 33'd1);
          walk_mode     = MODE_DATA;
        end
      end
      MODE_DATA: begin
        if (words_to_skip == '0) walk_mode = MODE_TAG;
        else words_to_skip = words_to_skip - 1'b1;
      end
      default: begin
        walk_mode     = MODE_TAG;
        ev.tag_offset = here;
        ev.depth      = cur_depth;
        fire          = 1'b1;
        case (w)
          TAG_BEGIN_NODE: begin
            if (cur_depth >= MAX_DEPTH_DEF) begin
              ev.kind      = EV_ERROR;
              walk_stopped = 1'b1;
            end else begin
              ev.kind   = EV_BEGIN;
              cur_depth = cur_depth + 1'b1;
              walk_mode = MODE_NAME;
            end
          end
          TAG_PROP: begin
            prop_tag_offset = here;
            walk_mode       = MODE_PLEN;
            fire            = 1'b0;
          end
          TAG_END_NODE: begin
            if (cur_depth == '0) begin
              ev.kind      = EV_ERROR;
              walk_stopped = 1'b1;
            end else begin
              cur_depth = cur_depth - 1'b1;
              ev.kind   = EV_END_NODE;
              ev.depth  = cur_depth;
            end
          end
          TAG_NOP: begin
            fire = 1'b0;
          end
          TAG_END: begin
            ev.kind      = EV_END;
            walk_stopped = 1'b1;
          end
          default: begin
            ev.kind      = EV_ERROR;
            walk_stopped = 1'b1;
          end
        endcase
      end
    endcase
    if (fire) pending_events.push_back(ev);
    if (!walk_stopped) cur_offset = here + 22'd4;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    walk_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got kind %0d data %0h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", 32'(want.kind), 32'(out_tuser));
        check_field("tag_offset", 32'(want.tag_offset), 32'(out_tdata[21:0]));
        check_field("depth", 32'(want.depth), 32'(out_tdata[28:22]));
        check_field("str_offset", want.str_offset, out_tdata[60:29]);
        check_field("prop_length", want.prop_length, out_tdata[92:61]);
        check_field("pad", 32'd0, 32'(out_tdata[95:93]));
      end
    end
  end

  initial begin : drive_ready
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_idle_en ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w, input logic first);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    walk_word(w, first);
  endtask

  task automatic stream_word(input logic [WORD_W-1:0] w);
    send_word(w, restart_pending);
    restart_pending = 1'b0;
    words_sent++;
  endtask

  task automatic halt_walk();
    repeat ($urandom_range(0, 2)) send_word($urandom, 1'b0);
    restart_pending = 1'b1;
  endtask

  function automatic logic [WORD_W-1:0] name_bytes();
    logic [WORD_W-1:0] w;
    for (int i = 0; i < 4; i++) w[8*i +: 8] = 8'($urandom_range(1, 255));
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] name_tail();
    logic [WORD_W-1:0] w;
    w = name_bytes();
    w[8*$urandom_range(0, 3) +: 8] = 8'h00;
    if ($urandom_range(0, 3) == 0) w = w & $urandom;
    return w;
  endfunction

  task automatic test_node_tokens();
    send_word(TAG_BEGIN_NODE, 1'b1);
    send_word(32'h6162_6364, 1'b0);
    send_word(32'h6566_00FF, 1'b0);
    send_word(TAG_BEGIN_NODE, 1'b0);
    send_word(32'h0061_6263, 1'b0);
    send_word(TAG_NOP, 1'b0);
    send_word(TAG_BEGIN_NODE, 1'b0);
    send_word(32'h6100_6263, 1'b0);
    send_word(TAG_END_NODE, 1'b0);
    send_word(TAG_BEGIN_NODE, 1'b0);
    send_word(32'h6162_6300, 1'b0);
    send_word(TAG_END_NODE, 1'b0);
    send_word(TAG_END_NODE, 1'b0);
    send_word(TAG_END_NODE, 1'b0);
    send_word(TAG_END, 1'b0);
  endtask

  task automatic test_properties();
    send_word(TAG_BEGIN_NODE, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(TAG_PROP, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(TAG_PROP, 1'b0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(TAG_PROP, 1'b0);
    send_word(32'h0000_0004, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(TAG_END, 1'b0);
    send_word(TAG_PROP, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b0);
    send_word(TAG_END, 1'b0);
    send_word(TAG_END, 1'b1);
    send_word(TAG_PROP, 1'b1);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(TAG_END_NODE, 1'b0);
  endtask

  task automatic test_stop_cases();
    send_word(TAG_END_NODE, 1'b1);
    send_word(TAG_BEGIN_NODE, 1'b0);
    send_word(TAG_END, 1'b0);
    send_word(32'hDEAD_BEEF, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    send_word(TAG_BEGIN_NODE, 1'b1);
    send_word(32'h4142_4300, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(TAG_NOP, 1'b0);
    send_word(TAG_BEGIN_NODE, 1'b1);
    send_word(32'h4141_4141, 1'b0);
    send_word(TAG_END, 1'b1);
    send_word(TAG_END_NODE, 1'b0);
  endtask

  task automatic test_depth_overflow();
    send_word(TAG_BEGIN_NODE, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    repeat (MAX_DEPTH_DEF) begin
      send_word(TAG_BEGIN_NODE, 1'b0);
      send_word(name_tail(), 1'b0);
    end
    send_word(TAG_END, 1'b1);
  endtask

  task automatic test_random_walks(input int budget);
    int          depth_guess;
    int          pick;
    int          next_shuffle;
    logic [31:0] len;
    logic [32:0] span;
    depth_guess     = 0;
    next_shuffle    = 0;
    words_sent      = 0;
    restart_pending = 1'b1;
    while (words_sent < budget) begin
      if (words_sent >= next_shuffle) begin
        in_idle_en   = $urandom_range(0, 2) != 0;
        out_idle_en  = $urandom_range(0, 2) != 0;
        next_shuffle = words_sent + 100;
      end
      if (restart_pending) depth_guess = 0;
      pick = (depth_guess == 0 && $urandom_range(0, 4) != 0) ? 0 : $urandom_range(0, 99);
      if (pick < 22 && depth_guess < 12) begin
        stream_word(TAG_BEGIN_NODE);
        depth_guess++;
        repeat ($urandom_range(0, 3)) stream_word(name_bytes());
        if ($urandom_range(0, 19) == 0) restart_pending = 1'b1;
        else stream_word(name_tail());
      end else if (pick < 50) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 24));
        span = ({1'b0, len} + 33'd3) >> 2;
        stream_word(TAG_PROP);
        stream_word(len);
        stream_word($urandom);
        if (span > 33'd48) begin
          repeat ($urandom_range(0, 3)) stream_word($urandom);
          restart_pending = 1'b1;
        end else begin
          repeat (int'(span)) stream_word($urandom);
        end
      end else if (pick < 72) begin
        stream_word(TAG_END_NODE);
        if (depth_guess == 0) halt_walk();
        else depth_guess--;
      end else if (pick < 80) begin
        stream_word(TAG_NOP);
      end else if (pick < 84) begin
        stream_word(TAG_END);
        halt_walk();
      end else if (pick < 88) begin
        stream_word($urandom);
        halt_walk();
      end else if (pick < 92) begin
        restart_pending = 1'b1;
      end else if (pick < 95) begin
        stream_word(32'($urandom_range(0, 15)));
        restart_pending = 1'b1;
      end else begin
        stream_word(TAG_NOP);
      end
    end
  endtask

  initial begin
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    rst_n       <= 1'b0;
    mismatches  = 0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    clear_walk();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_node_tokens();
    test_properties();
    test_stop_cases();
    test_depth_overflow();
    test_random_walks(1000);

    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** device_tree_token_walker: PASSED **");
    end else begin
      $display("** device_tree_token_walker: FAILED **");
    end
    $finish;
  end

endmodule
